@@ sv/csf_pkg.sv @@
// ----------------------------------------------------------------------------
// csf_pkg: shared types and constants of the cave smoothing filter
// Line buffer sizing, register indexes, the configuration bundle and the
// entry format of the queue between the front and back parts.
// ----------------------------------------------------------------------------
package csf_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int COL_W       = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W       = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] REG_GRID_WIDTH    = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_WALL_AT_LEAST = 3'd2;
  localparam logic [2:0] REG_FLOOR_BELOW   = 3'd3;
  localparam logic [2:0] REG_WALL_CODE     = 3'd4;
  localparam logic [2:0] REG_FLOOR_CODE    = 3'd5;

  localparam logic ACTION_CELL  = 1'b0;
  localparam logic ACTION_FLUSH = 1'b1;

  typedef struct packed {
    logic       walkable;
    logic [2:0] tile;
  } cell_t;

  // Effective settings as seen by both parts; sizes are already saturated.
  typedef struct packed {
    logic [COL_W-1:0] width;
    logic [ROW_W-1:0] height;
    logic [3:0]       wall_at_least;
    logic [3:0]       floor_below;
    logic [2:0]       wall_code;
    logic [2:0]       floor_code;
    logic             restart;
  } cfg_t;

  // One window step for the back part: a real or dummy cell and its column.
  typedef struct packed {
    cell_t             grid_cell;
    logic [ADDR_W-1:0] addr;
    logic              emit;
    logic              last;
  } feed_t;

endpackage

@@ sv/csf_front.sv @@
// ----------------------------------------------------------------------------
// csf_front: input side of the cave smoothing filter
// Accepts items, tracks the raster position and turns cells and flushes
// into window steps for the back part, dropping items that do nothing.
// ----------------------------------------------------------------------------
module csf_front (
  input  logic                clk,
  input  logic                rst,
  input  csf_pkg::cfg_t       cfg,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic [0:0]          s_tuser,
  input  logic                q_full,
  output logic                push,
  output csf_pkg::feed_t      push_data
);
  import csf_pkg::*;

  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic             accept;
  logic             in_frame;
  logic             is_flush;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign is_flush = (s_tuser[0] == ACTION_FLUSH);
  assign in_frame = (in_row < cfg.height);

  always_comb begin
    push_data.grid_cell = cell_t'(s_tdata[3:0]);
    push_data.addr      = in_col[ADDR_W-1:0];
    push_data.emit      = 1'b1;
    push_data.last      = 1'b0;
    push                = 1'b0;
    if (accept) begin
      if (!is_flush) begin
        push = in_frame;
        // A result is due once the cell below and right of it has arrived.
        push_data.emit = (in_row >= ROW_W'(2)) || (in_row == ROW_W'(1) && in_col != '0);
      end else begin
        // Flushes feed dummy cells past the grid; they are masked as out of bounds.
        push                = !in_frame;
        push_data.grid_cell = '0;
        push_data.last      = (in_col == cfg.width);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      in_col <= '0;
      in_row <= '0;
    end else if (push) begin
      if (!is_flush) begin
        if (in_col == cfg.width - COL_W'(1)) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end else if (push_data.last) begin
        in_col <= '0;
        in_row <= '0;
      end else begin
        in_col <= in_col + COL_W'(1);
      end
    end
  end

endmodule

@@ sv/csf_queue.sv @@
// ----------------------------------------------------------------------------
// csf_queue: short queue between front and back parts
// A small register queue of window steps that lets either side stall.
// ----------------------------------------------------------------------------
module csf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  csf_pkg::feed_t push_data,
  input  logic           pop,
  output csf_pkg::feed_t pop_data,
  output logic           full,
  output logic           empty
);
  import csf_pkg::*;

  feed_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[head];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + QPTR_W'(1);
      end
      if (pop) begin
        head <= head + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

@@ sv/csf_back.sv @@
// ----------------------------------------------------------------------------
// csf_back: window and decision side of the cave smoothing filter
// Two line buffers feed a 3x3 window; the in-bounds walls around the
// center are counted and the new tile is held in the output register.
// ----------------------------------------------------------------------------
module csf_back (
  input  logic           clk,
  input  logic           rst,
  input  csf_pkg::cfg_t  cfg,
  input  logic           q_empty,
  input  csf_pkg::feed_t q_head,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tlast
);
  import csf_pkg::*;

  cell_t            lb_mid [MAX_WIDTH];
  cell_t            lb_top [MAX_WIDTH];
  cell_t            rd_mid;
  cell_t            rd_top;
  feed_t            a_feed;
  logic             a_valid;
  cell_t            win [3][3];
  logic             b_valid;
  logic             b_last;
  logic [ADDR_W-1:0] kc;
  logic [ROW_W-1:0] kr;
  logic             out_valid;
  logic [2:0]       out_tile;
  logic             out_walk;
  logic             out_last;
  logic             adv;
  logic [3:0]       walls;
  logic             row_ok [3];
  logic             col_ok [3];
  logic [2:0]       tile_next;
  logic             walk_next;
  logic             k_last_col;

  assign adv      = !out_valid || m_tready;
  assign q_pop    = adv && !q_empty;
  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_walk, out_tile};
  assign m_tlast  = out_last;
  assign k_last_col = ({1'b0, kc} == cfg.width - COL_W'(1));

  // Line buffers: the middle one holds the previous row, the top one the row
  // before that. A column is read when its step leaves the queue and written
  // when that step moves on out of a_feed, so neighboring steps never hit the same column.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_mid <= lb_mid[q_head.addr];
      rd_top <= lb_top[q_head.addr];
      a_feed <= q_head;
    end
    if (adv && a_valid) begin
      lb_mid[a_feed.addr] <= a_feed.grid_cell;
      lb_top[a_feed.addr] <= rd_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= rd_top;
      win[1][2] <= rd_mid;
      win[2][2] <= a_feed.grid_cell;
    end
    if (adv) begin
      b_last <= a_feed.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= q_pop;
      b_valid <= a_valid && a_feed.emit;
    end
  end

  // Neighbors off the grid are masked by the center cell's row and column.
  always_comb begin
    row_ok[0] = (kr != '0);
    row_ok[1] = 1'b1;
    row_ok[2] = (kr != cfg.height - ROW_W'(1));
    col_ok[0] = (kc != '0);
    col_ok[1] = 1'b1;
    col_ok[2] = !k_last_col;
    walls     = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!(r == 1 && c == 1) && row_ok[r] && col_ok[c] && !win[r][c].walkable) begin
          walls = walls + 4'd1;
        end
      end
    end
    if (walls >= cfg.wall_at_least) begin
      tile_next = cfg.wall_code;
      walk_next = 1'b0;
    end else if (walls < cfg.floor_below) begin
      tile_next = cfg.floor_code;
      walk_next = 1'b1;
    end else begin
      tile_next = win[1][1].tile;
      walk_next = win[1][1].walkable;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tile <= tile_next;
      out_walk <= walk_next;
      out_last <= b_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      kc <= '0;
      kr <= '0;
    end else if (adv && b_valid) begin
      if (b_last) begin
        kc <= '0;
        kr <= '0;
      end else if (k_last_col) begin
        kc <= '0;
        kr <= kr + ROW_W'(1);
      end else begin
        kc <= kc + ADDR_W'(1);
      end
    end
  end

endmodule

@@ sv/cave_smoothing_filter.sv @@
// ----------------------------------------------------------------------------
// cave_smoothing_filter: one pass of the wall/floor cave smoothing automaton
// Cells enter on the s_ channel in raster order; smoothed cells leave on the
// m_ channel one grid line plus one cell later. A flush item (tuser set)
// after the last cell of a grid pushes out one of the remaining results;
// grid_width + 1 flushes drain a frame, and the result of the final cell
// carries tlast. Cells arriving after a full frame and flushes with nothing
// pending are taken and dropped.
// The block takes one item per clock unless the queue is full: each step does
// one read and one write of the two line buffers, and the window feeds the
// wall count and the output register. A short queue separates input and
// output, so s_tready drops only when the receiver has stalled long enough to
// fill it; m_ data holds while stalled. Reset loads the default grid of 80 by
// 50 with thresholds 5 and 4 and clears the pipeline. Line buffers need no
// clearing pass. Writing the grid width or height restarts the frame.
// The user writes configuration only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module cave_smoothing_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [2:0] cell_tile, [3] cell_walkable
  input  logic [0:0]  s_tuser,    // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [2:0] out_tile, [3] out_walkable
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import csf_pkg::*;

  logic [7:0]  grid_width;
  logic [11:0] grid_height;
  logic [3:0]  wall_at_least;
  logic [3:0]  floor_below;
  logic [2:0]  wall_code;
  logic [2:0]  floor_code;
  cfg_t        cfg;
  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;
  feed_t       push_data;
  feed_t       q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= 8'd80;
      grid_height   <= 12'd50;
      wall_at_least <= 4'd5;
      floor_below   <= 4'd4;
      wall_code     <= 3'd2;
      floor_code    <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:    grid_width    <= cfg_data[7:0];
        REG_GRID_HEIGHT:   grid_height   <= cfg_data[11:0];
        REG_WALL_AT_LEAST: wall_at_least <= cfg_data[3:0];
        REG_FLOOR_BELOW:   floor_below   <= cfg_data[3:0];
        REG_WALL_CODE:     wall_code     <= cfg_data[2:0];
        REG_FLOOR_CODE:    floor_code    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Sizes out of range are saturated here.
  always_comb begin
    if (grid_width < 8'd3) begin
      cfg.width = COL_W'(3);
    end else if (COL_W'(grid_width) > COL_W'(MAX_WIDTH)) begin
      cfg.width = COL_W'(MAX_WIDTH);
    end else begin
      cfg.width = COL_W'(grid_width);
    end
    cfg.height        = (grid_height < 12'd3) ? ROW_W'(3) : ROW_W'(grid_height);
    cfg.wall_at_least = wall_at_least;
    cfg.floor_below   = floor_below;
    cfg.wall_code     = wall_code;
    cfg.floor_code    = floor_code;
    cfg.restart       = cfg_we &&
                        (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);
  end

  csf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (push_data)
  );

  csf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  csf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for cave_smoothing_filter
// Streams grids of cells in raster order, with flush items to drain each
// frame. A behavioral model of the smoothing pass predicts every smoothed
// item, and a checker compares each output item against the oldest
// prediction. Both stream sides insert random idle cycles. Grid sizes,
// thresholds and tile codes change only while the filter is idle, at times
// before a frame is complete.
// ----------------------------------------------------------------------------
module testbench;
  import csf_pkg::*;

  localparam int          RING_DEPTH   = 2 * MAX_WIDTH + 4;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 470;

  typedef struct packed {
    cell_t smoothed;
    logic  last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [2:0] cell_tile, [3] cell_walkable
  logic [0:0]  s_tuser = '0;   // [0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [2:0] out_tile, [3] out_walkable
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  cave_smoothing_filter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model of the filter: settings, ring of received cells and frame counters.
  logic [7:0]  set_width;
  logic [11:0] set_height;
  logic [3:0]  wall_min;
  logic [3:0]  floor_max;
  logic [2:0]  wall_tile;
  logic [2:0]  floor_tile;
  cell_t       ring [RING_DEPTH];
  int unsigned col_in, row_in, next_out;

  result_t     pending_cells [$];
  result_t     want;
  int unsigned used_items = 0;
  int unsigned failures = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;

  function automatic int unsigned eff_width();
    if (set_width < 3) return 3;
    if (set_width > MAX_WIDTH) return MAX_WIDTH;
    return set_width;
  endfunction

  function automatic int unsigned eff_height();
    return (set_height < 3) ? 3 : set_height;
  endfunction

  function automatic void restart_frame();
    col_in = 0;
    row_in = 0;
    next_out = 0;
  endfunction

  function automatic void reset_model();
    set_width  = 8'd80;
    set_height = 12'd50;
    wall_min   = 4'd5;
    floor_max  = 4'd4;
    wall_tile  = 3'd2;
    floor_tile = 3'd1;
    foreach (ring[i]) ring[i] = '0;
    restart_frame();
  endfunction

  function automatic void apply_setting(logic [2:0] idx, logic [11:0] value);
    case (idx)
      REG_GRID_WIDTH: begin
        set_width = value[7:0];
        restart_frame();
      end
      REG_GRID_HEIGHT: begin
        set_height = value;
        restart_frame();
      end
      REG_WALL_AT_LEAST: wall_min = value[3:0];
      REG_FLOOR_BELOW:   floor_max = value[3:0];
      REG_WALL_CODE:     wall_tile = value[2:0];
      REG_FLOOR_CODE:    floor_tile = value[2:0];
      default: ;
    endcase
  endfunction

  // Smooths the cell at next_out from its in-bounds neighbors and advances.
  function automatic result_t smooth_next();
    int unsigned w, h, walls;
    int          r, c, nr, nc, dr, dc;
    result_t     res;
    w = eff_width();
    h = eff_height();
    r = next_out / w;
    c = next_out % w;
    walls = 0;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        nr = r + dr;
        nc = c + dc;
        if ((dr != 0 || dc != 0) && nr >= 0 && nr < int'(h) && nc >= 0 && nc < int'(w)) begin
          if (!ring[(nr * int'(w) + nc) % RING_DEPTH].walkable) walls++;
        end
      end
    end
    if (walls >= wall_min)
      res.smoothed = '{walkable: 1'b0, tile: wall_tile};
    else if (walls < floor_max)
      res.smoothed = '{walkable: 1'b1, tile: floor_tile};
    else
      res.smoothed = ring[next_out % RING_DEPTH];
    res.last = (next_out == w * h - 1);
    next_out++;
    if (next_out >= w * h) restart_frame();
    return res;
  endfunction

  // Returns 1 when the item yields a smoothed cell; used is 0 for dropped items.
  function automatic bit step_grid(input logic act, input cell_t incoming,
                                   output result_t res, output bit used);
    int unsigned w, h, got;
    w = eff_width();
    h = eff_height();
    used = 1'b0;
    res = '0;
    if (act == ACTION_CELL) begin
      if (row_in >= h) return 1'b0;
      used = 1'b1;
      got = row_in * w + col_in;
      ring[got % RING_DEPTH] = incoming;
      got++;
      col_in++;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
      end
      if (got >= next_out + w + 2) begin
        res = smooth_next();
        return 1'b1;
      end
      return 1'b0;
    end
    if (row_in >= h && next_out < w * h) begin
      used = 1'b1;
      res = smooth_next();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int unsigned draw_gap();
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  task automatic send_item(input logic act, input logic [2:0] tile, input logic walk);
    int unsigned gap;
    result_t     res;
    bit          used;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, walk, tile};
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
    if (step_grid(act, '{walkable: walk, tile: tile}, res, used))
      pending_cells.insert(pending_cells.size(), res);
    if (used) used_items++;
  endtask

  task automatic send_cells(input int unsigned count, input int unsigned density);
    repeat (count)
      send_item(ACTION_CELL, 3'($urandom_range(0, 7)), $urandom_range(0, 99) >= density);
  endtask

  task automatic send_flushes(input int unsigned count);
    repeat (count) send_item(ACTION_FLUSH, 3'($urandom_range(0, 7)), 1'($urandom));
  endtask

  // Waits until every predicted item has arrived, then lets the pipeline settle.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] value);
    @(negedge clk);
    s_tvalid  <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    apply_setting(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: stalls for a freshly drawn number of cycles after each item.
  initial begin
    int unsigned hold;
    @(negedge clk);
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        hold = draw_gap();
        if (hold > 0) begin
          @(negedge clk);
          m_tready <= 1'b0;
          repeat (hold) @(negedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_cells.size() == 0) begin
        $error("unexpected item: out_tile %0d out_walkable %0d frame_last %0d",
               m_tdata[2:0], m_tdata[3], m_tlast);
        failures++;
      end else begin
        want = pending_cells.pop_front();
        if (m_tdata[2:0] !== want.smoothed.tile) begin
          $error("out_tile: expected %0d, got %0d", want.smoothed.tile, m_tdata[2:0]);
          failures++;
        end
        if (m_tdata[3] !== want.smoothed.walkable) begin
          $error("out_walkable: expected %0d, got %0d", want.smoothed.walkable, m_tdata[3]);
          failures++;
        end
        if (m_tlast !== want.last) begin
          $error("frame_last: expected %0d, got %0d", want.last, m_tlast);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** cave_smoothing_filter: FAILED **");
      $finish;
    end
  end

  // The reset grid is 80 wide, so the first 81 cells produce nothing.
  task automatic test_reset_defaults();
    send_cells(100, 50);
    drain_results();
  endtask

  // A 3 by 3 grid: corners see only three neighbors, so with all walls they
  // turn to floor while edges and the center turn to wall.
  task automatic test_corner_cells();
    int unsigned i;
    write_reg(REG_GRID_WIDTH, 12'd0);
    write_reg(REG_GRID_HEIGHT, 12'd2);
    write_reg(REG_WALL_CODE, 12'd7);
    write_reg(REG_FLOOR_CODE, 12'd0);
    for (i = 0; i < 9; i++) begin
      send_item(ACTION_CELL, 3'(i), 1'b0);
      // A flush before the frame is complete yields nothing.
      if (i == 2) send_flushes(1);
    end
    // Cells after a full frame are dropped until it is drained.
    send_item(ACTION_CELL, 3'd7, 1'b1);
    send_item(ACTION_CELL, 3'd0, 1'b0);
    send_flushes(5);
    drain_results();
    // Wall threshold above the largest count and floor threshold zero: every cell keeps its tile.
    write_reg(REG_WALL_AT_LEAST, 12'd15);
    write_reg(REG_FLOOR_BELOW, 12'd0);
    for (i = 0; i < 9; i++) send_item(ACTION_CELL, 3'(7 - i), 1'(i));
    send_flushes(4);
    drain_results();
  endtask

  task automatic test_size_extremes();
    write_reg(REG_WALL_AT_LEAST, 12'd5);
    write_reg(REG_FLOOR_BELOW, 12'd4);
    write_reg(REG_GRID_WIDTH, 12'd128);
    write_reg(REG_GRID_HEIGHT, 12'd3);
    send_cells(384, 45);
    send_flushes(129);
    drain_results();
    // Oversized width saturates; the tall frame is cut short by a size write.
    write_reg(REG_GRID_WIDTH, 12'd255);
    write_reg(REG_GRID_HEIGHT, 12'd4095);
    send_cells(300, 55);
    drain_results();
    write_reg(REG_GRID_HEIGHT, 12'd1);
    send_cells(384, 60);
    send_flushes(129);
    drain_results();
    // Only the low byte of the width write counts.
    write_reg(REG_GRID_WIDTH, 12'hF05);
    write_reg(REG_GRID_HEIGHT, 12'd3);
    send_cells(15, 50);
    send_flushes(6);
    drain_results();
  endtask

  function automatic logic [3:0] pick_threshold();
    return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
  endfunction

  task automatic test_random_grids();
    int unsigned goal, w, h, cells, density, pick, i;
    bit          cut_short;
    goal = used_items + RANDOM_ITEMS;
    cut_short = 1'b1;
    while (used_items < goal) begin
      drain_results();
      quiet = ($urandom_range(0, 3) == 0);
      if (cut_short || $urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)      w = $urandom_range(0, 2);
        else if (pick == 1) w = $urandom_range(129, 255);
        else if (pick <= 3) w = $urandom_range(11, 128);
        else                w = $urandom_range(3, 10);
        if (w > 10)                        h = $urandom_range(3, 4);
        else if ($urandom_range(0, 19) == 0) h = $urandom_range(0, 2);
        else                               h = $urandom_range(3, 6);
        write_reg(REG_GRID_WIDTH, {4'($urandom), 8'(w)});
        write_reg(REG_GRID_HEIGHT, 12'(h));
        cut_short = 1'b0;
      end
      write_reg(REG_WALL_AT_LEAST, {8'($urandom), pick_threshold()});
      write_reg(REG_FLOOR_BELOW, {8'($urandom), pick_threshold()});
      write_reg(REG_WALL_CODE, 12'($urandom));
      write_reg(REG_FLOOR_CODE, 12'($urandom));
      repeat ($urandom_range(1, 3)) begin
        w = eff_width();
        h = eff_height();
        cells = w * h;
        if ($urandom_range(0, 9) == 0) begin
          cells = $urandom_range(1, w * h - 1);
          cut_short = 1'b1;
        end
        density = $urandom_range(0, 100);
        for (i = 0; i < cells; i++) begin
          if ($urandom_range(0, 29) == 0) send_flushes(1);
          send_cells(1, density);
        end
        if (cut_short) break;
        if ($urandom_range(0, 3) == 0) send_cells($urandom_range(1, 3), density);
        send_flushes(w + 1 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0));
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_corner_cells();
    test_size_extremes();
    test_random_grids();
    drain_results();
    if (failures == 0) begin
      $display("** cave_smoothing_filter: PASSED **");
    end else begin
      $display("** cave_smoothing_filter: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/csf_pkg.sv
sv/csf_front.sv
sv/csf_queue.sv
sv/csf_back.sv
sv/cave_smoothing_filter.sv
tb/sv/testbench.sv
